// ----- sv/hfth_pkg.sv -----
// Shared types and constants for the heightfield triangle height block.
// Holds field widths, the item kind codes and the register index codes.
// No dependencies.
package hfth_pkg;

    // Item kinds carried in s_tuser
    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    // Register indexes of the configuration port
    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    // Fixed field widths
    localparam int IDX_W     = 12;
    localparam int HEIGHT_W  = 32;
    localparam int CFG_W     = 7;
    localparam int IN_DATA_W = 144;  // 140 bits of fields, padded to bytes

    // Reset value of both grid size registers
    localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 7'd64;

endpackage

// ----- sv/heightfield_triangle_height.sv -----
// Heightfield triangle height: height store and query pipeline in one module.
// Depends on hfth_pkg for field widths, kind codes and register indexes.
//
// The block accepts one transaction per cycle while s_tready is high, loads
// and queries alike. Heights live in two copies of a word store of depth
// MAX_GRID_SIDE*MAX_GRID_SIDE; each load whose index fits in it writes both
// copies, and each copy serves two of the four corner reads of a cell, so a
// query needs a single access to each read port. A load is written in the
// cycle it is accepted and is seen by every query accepted after it. The
// store has no reset and no clearing pass: a query must only touch vertices
// already loaded. Results leave in order; loads give no result. grid_columns
// and grid_rows must be written only while no query is in flight (unchecked).
module heightfield_triangle_height #(
    parameter int MAX_GRID_SIDE   = 64,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [hfth_pkg::CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [11:0] vertex_index, [43:12] vertex_height, [75:44] query_x,
    // [107:76] query_z, [139:108] height_offset, [143:140] zero
    input  logic [hfth_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] surface_height
    output logic [hfth_pkg::HEIGHT_W-1:0]   m_tdata,
    // [0] outside_grid
    output logic                            m_tuser
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_GRID_SIDE + 1);
    localparam int CW    = (SW > hfth_pkg::CFG_W) ? SW : hfth_pkg::CFG_W;
    localparam int IW    = (AW > hfth_pkg::IDX_W) ? AW : hfth_pkg::IDX_W;
    localparam int XW    = 31 - F;
    localparam int KW    = (XW > CW) ? XW : CW;
    localparam int DW    = 33;
    localparam int PRW   = DW + F + 2;
    localparam int ACCW  = PRW + 2;
    localparam int HW    = ACCW - F;
    localparam int SUMW  = HW + 1;

    localparam logic [F:0]           ONE    = {1'b1, {F{1'b0}}};
    localparam logic [ACCW-1:0]      HALF   = ACCW'({1'b1, {(F-1){1'b0}}});
    localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW-31){1'b1}}, {31{1'b0}}};

    // input field unpacking
    logic [hfth_pkg::IDX_W-1:0] in_index;
    logic [31:0]                in_height;
    logic [31:0]                in_x;
    logic [31:0]                in_z;
    logic [31:0]                in_offset;
    logic                       in_query;

    assign in_index  = s_tdata[11:0];
    assign in_height = s_tdata[43:12];
    assign in_x      = s_tdata[75:44];
    assign in_z      = s_tdata[107:76];
    assign in_offset = s_tdata[139:108];
    assign in_query  = (hfth_pkg::mode_t'(s_tuser) == hfth_pkg::MODE_QUERY);

    // configuration registers
    logic [hfth_pkg::CFG_W-1:0] cols_cfg_reg;
    logic [hfth_pkg::CFG_W-1:0] rows_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= hfth_pkg::GRID_SIDE_RESET;
            rows_cfg_reg <= hfth_pkg::GRID_SIDE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hfth_pkg::REG_GRID_COLUMNS: cols_cfg_reg <= cfg_wdata;
                hfth_pkg::REG_GRID_ROWS:    rows_cfg_reg <= cfg_wdata;
                default:                    cols_cfg_reg <= cols_cfg_reg;
            endcase
        end
    end

    // stage valids and load enables, each stage fills when it is empty or
    // when its content moves on
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5 = !v5_reg || m_tready;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign s_tready = ld1;

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_accept && in_query;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // stage 1: cell lookup, range check and base address
    logic [CW-1:0]  cols_eff, rows_eff;
    logic [KW-1:0]  col_k, row_k;
    logic [F-1:0]   fx_s0, fz_s0;
    logic           outside_s0;
    logic           upper_s0;
    logic [SW-1:0]  col_s0, row_s0, cols_s0;
    logic [AW-1:0]  base_s0;

    always_comb begin
        cols_eff = (CW'(cols_cfg_reg) > CW'(MAX_GRID_SIDE)) ? CW'(MAX_GRID_SIDE)
                                                            : CW'(cols_cfg_reg);
        rows_eff = (CW'(rows_cfg_reg) > CW'(MAX_GRID_SIDE)) ? CW'(MAX_GRID_SIDE)
                                                            : CW'(rows_cfg_reg);
        col_k    = KW'(in_x[30:F]);
        row_k    = KW'(in_z[30:F]);
        fx_s0    = in_x[F-1:0];
        fz_s0    = in_z[F-1:0];
        // a point on the far edge counts as outside
        outside_s0 = in_x[31] || in_z[31]
                  || (cols_eff < CW'(2)) || (rows_eff < CW'(2))
                  || (col_k >= KW'(cols_eff - CW'(1)))
                  || (row_k >= KW'(rows_eff - CW'(1)));
        upper_s0 = ((F+1)'(fx_s0) + (F+1)'(fz_s0)) > ONE;
        col_s0   = col_k[SW-1:0];
        row_s0   = row_k[SW-1:0];
        cols_s0  = cols_eff[SW-1:0];
        base_s0  = AW'(row_s0 * cols_s0) + AW'(col_s0);
    end

    logic [AW-1:0]  base_s1_reg;
    logic [SW-1:0]  cols_s1_reg;
    logic [F-1:0]   fx_s1_reg, fz_s1_reg;
    logic           upper_s1_reg, outside_s1_reg;
    logic [31:0]    off_s1_reg;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            base_s1_reg    <= base_s0;
            cols_s1_reg    <= cols_s0;
            fx_s1_reg      <= fx_s0;
            fz_s1_reg      <= fz_s0;
            upper_s1_reg   <= upper_s0;
            outside_s1_reg <= outside_s0;
            off_s1_reg     <= in_offset;
        end
    end

    // height store: two copies, each written by every load whose index fits
    logic [IW-1:0] widx;
    logic          st_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] a00, a10, a01, a11;

    assign widx  = IW'(in_index);
    // compare one bit wider so that a power-of-two depth does not wrap to zero
    assign st_we = s_accept && !in_query && ((IW+1)'(widx) < (IW+1)'(DEPTH));
    assign waddr = widx[AW-1:0];

    assign a00 = base_s1_reg;
    assign a10 = base_s1_reg + AW'(1);
    assign a01 = base_s1_reg + AW'(cols_s1_reg);
    assign a11 = a01 + AW'(1);

    logic [31:0] mem_a [DEPTH];
    logic [31:0] mem_b [DEPTH];
    logic signed [31:0] h00_reg, h10_reg, h01_reg, h11_reg;

    // stage 2: corner reads, old data wins on a read and write to one word
    always_ff @(posedge aclk) begin
        if (st_we) mem_a[waddr] <= in_height;
        if (ld2) begin
            h00_reg <= mem_a[a00];
            h10_reg <= mem_a[a10];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) mem_b[waddr] <= in_height;
        if (ld2) begin
            h01_reg <= mem_b[a01];
            h11_reg <= mem_b[a11];
        end
    end

    logic [F-1:0]   fx_s2_reg, fz_s2_reg;
    logic           upper_s2_reg, outside_s2_reg;
    logic [31:0]    off_s2_reg;

    always_ff @(posedge aclk) begin
        if (ld2) begin
            fx_s2_reg      <= fx_s1_reg;
            fz_s2_reg      <= fz_s1_reg;
            upper_s2_reg   <= upper_s1_reg;
            outside_s2_reg <= outside_s1_reg;
            off_s2_reg     <= off_s1_reg;
        end
    end

    // stage 3: pick the triangle, form anchor, edge deltas and weights
    logic signed [31:0]   a_next;
    logic signed [DW-1:0] d1_next, d2_next;
    logic [F:0]           w1_next, w2_next;

    always_comb begin
        if (upper_s2_reg) begin
            a_next  = h11_reg;
            d1_next = DW'(h01_reg) - DW'(h11_reg);
            d2_next = DW'(h10_reg) - DW'(h11_reg);
            w1_next = ONE - (F+1)'(fx_s2_reg);
            w2_next = ONE - (F+1)'(fz_s2_reg);
        end else begin
            a_next  = h00_reg;
            d1_next = DW'(h10_reg) - DW'(h00_reg);
            d2_next = DW'(h01_reg) - DW'(h00_reg);
            w1_next = (F+1)'(fx_s2_reg);
            w2_next = (F+1)'(fz_s2_reg);
        end
    end

    logic signed [31:0]   a_s3_reg;
    logic signed [DW-1:0] d1_s3_reg, d2_s3_reg;
    logic [F:0]           w1_s3_reg, w2_s3_reg;
    logic                 outside_s3_reg;
    logic [31:0]          off_s3_reg;

    always_ff @(posedge aclk) begin
        if (ld3) begin
            a_s3_reg       <= a_next;
            d1_s3_reg      <= d1_next;
            d2_s3_reg      <= d2_next;
            w1_s3_reg      <= w1_next;
            w2_s3_reg      <= w2_next;
            outside_s3_reg <= outside_s2_reg;
            off_s3_reg     <= off_s2_reg;
        end
    end

    // stage 4: weight both edge deltas
    logic signed [PRW-1:0] p1_next, p2_next;

    assign p1_next = d1_s3_reg * $signed({1'b0, w1_s3_reg});
    assign p2_next = d2_s3_reg * $signed({1'b0, w2_s3_reg});

    logic signed [31:0]    a_s4_reg;
    logic signed [PRW-1:0] p1_s4_reg, p2_s4_reg;
    logic                  outside_s4_reg;
    logic signed [31:0]    off_s4_reg;

    always_ff @(posedge aclk) begin
        if (ld4) begin
            a_s4_reg       <= a_s3_reg;
            p1_s4_reg      <= p1_next;
            p2_s4_reg      <= p2_next;
            outside_s4_reg <= outside_s3_reg;
            off_s4_reg     <= off_s3_reg;
        end
    end

    // stage 5: sum, round half up, add offset, saturate, zero when outside
    logic signed [ACCW-1:0] acc;
    logic signed [ACCW-1:0] acc_rnd;
    logic signed [HW-1:0]   h_round;
    logic signed [SUMW-1:0] sum;
    logic [31:0]            height_next;

    always_comb begin
        acc     = (ACCW'(a_s4_reg) <<< F) + ACCW'(p1_s4_reg) + ACCW'(p2_s4_reg);
        acc_rnd = acc + $signed(HALF);
        h_round = HW'(acc_rnd >>> F);
        sum     = SUMW'(h_round) + SUMW'(off_s4_reg);
        if (outside_s4_reg) begin
            height_next = '0;
        end else if (sum > SAT_HI) begin
            height_next = SAT_HI[31:0];
        end else if (sum < SAT_LO) begin
            height_next = SAT_LO[31:0];
        end else begin
            height_next = sum[31:0];
        end
    end

    logic [31:0] height_reg;
    logic        outside_reg;

    always_ff @(posedge aclk) begin
        if (ld5) begin
            height_reg  <= height_next;
            outside_reg <= outside_s4_reg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = height_reg;
    assign m_tuser  = outside_reg;

    // checks
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("outside query carries nonzero height");

    a_ready_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg)
        else $error("input stalled with empty first stage");

    a_query_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == hfth_pkg::MODE_QUERY |=> v1_reg)
        else $error("accepted query missing from first stage");

    a_read_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !ld3 |=> v2_reg && $stable(h00_reg) && $stable(h11_reg))
        else $error("stalled corner heights changed");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for heightfield_triangle_height: loads and queries go in
// on the input stream; each query result is checked against a predicted or
// typed answer. Depends on hfth_pkg and the heightfield_triangle_height module.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     GRID_SIDE_MAX = 64;
    localparam int     FRAC_BITS     = 16;
    localparam int     STORE_WORDS   = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam longint UNIT          = 64'sd1 <<< FRAC_BITS;
    localparam longint SAT_HI        = 64'sd2147483647;
    localparam longint SAT_LO        = -64'sd2147483648;
    localparam int     NUM_PHASES    = 10;
    localparam int     PHASE_ITEMS   = 55;
    localparam int     NUM_DIRECTED  = 22;

    typedef struct packed {
        logic [hfth_pkg::HEIGHT_W-1:0] height;
        logic                          outside;
    } result_t;

    typedef struct packed {
        hfth_pkg::mode_t               mode;
        logic [hfth_pkg::IDX_W-1:0]    index;
        logic [31:0]                   vheight;
        logic [31:0]                   qx;
        logic [31:0]                   qz;
        logic [31:0]                   offset;
        logic                          typed;
        result_t                       answer;
    } stim_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic                             cfg_index;
    logic [hfth_pkg::CFG_W-1:0]       cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [hfth_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [hfth_pkg::HEIGHT_W-1:0]    m_tdata;
    logic                             m_tuser;

    // predictor state: vertex heights, which entries were loaded, grid size
    logic [31:0]                      height_mem [0:STORE_WORDS-1];
    bit                               height_loaded [0:STORE_WORDS-1];
    logic [hfth_pkg::CFG_W-1:0]       grid_cols_cfg;
    logic [hfth_pkg::CFG_W-1:0]       grid_rows_cfg;

    result_t                pending_surfaces [$];
    result_t                want;
    int                     errors;
    bit                     quiet_tail;
    bit                     sender_busy;

    int phase_cols [0:NUM_PHASES-1] = '{2, 0, 1, 127, 65, 8, 64, 2, 37, 5};
    int phase_rows [0:NUM_PHASES-1] = '{2, 5, 64, 3, 70, 6, 64, 64, 2, 9};

    // directed rows run on the reset grid of 64 x 64
    stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{hfth_pkg::MODE_LOAD,  12'd0,  32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{hfth_pkg::MODE_LOAD,  12'd1,  32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{hfth_pkg::MODE_LOAD,  12'd64, 32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{hfth_pkg::MODE_LOAD,  12'd65, 32'hFFFF0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        // exact vertex, then saturate high, then sum to minus one
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0,
          1'b1, '{32'h7FFFFFFF, 1'b0}},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF,
          1'b1, '{32'h7FFFFFFF, 1'b0}},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h0, 32'h0, 32'h80000000,
          1'b1, '{32'hFFFFFFFF, 1'b0}},
        // diagonal tie stays lower-left, then upper-right, then just past tie
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h00008000, 32'h00008000, 32'h0,
          1'b0, '0},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h0000FFFF, 32'h0000FFFF, 32'h0,
          1'b0, '0},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h00008001, 32'h00008000, 32'd12345,
          1'b0, '0},
        // outside: negative x, negative z, far column, far row, huge point
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h80000000, 32'h0, 32'h1234,
          1'b1, '{32'h0, 1'b1}},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h1234,
          1'b1, '{32'h0, 1'b1}},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h003F0000, 32'h0, 32'h0,
          1'b1, '{32'h0, 1'b1}},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h0, 32'h003F0000, 32'h0,
          1'b1, '{32'h0, 1'b1}},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
          1'b1, '{32'h0, 1'b1}},
        // last cell of the grid
        '{hfth_pkg::MODE_LOAD, 12'd4030, 32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{hfth_pkg::MODE_LOAD, 12'd4031, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{hfth_pkg::MODE_LOAD, 12'd4094, 32'h00000000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{hfth_pkg::MODE_LOAD, 12'd4095, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h003E0000, 32'h003E0000, 32'h80000000,
          1'b1, '{32'h80000000, 1'b0}},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h003EFFFF, 32'h003EFFFF, 32'h7FFFFFFF,
          1'b0, '0},
        '{hfth_pkg::MODE_QUERY, 12'd0, 32'h0, 32'h003E4000, 32'h003EC000, 32'h0,
          1'b0, '0}
    };

    heightfield_triangle_height #(
        .MAX_GRID_SIDE   (GRID_SIDE_MAX),
        .COORD_FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int clamp_side(input logic [hfth_pkg::CFG_W-1:0] side);
        return (side > GRID_SIDE_MAX) ? GRID_SIDE_MAX : int'(side);
    endfunction

    function automatic logic [hfth_pkg::IN_DATA_W-1:0] pack_item(
            input logic [hfth_pkg::IDX_W-1:0] index,
            input logic [31:0] vheight,
            input logic [31:0] qx,
            input logic [31:0] qz,
            input logic [31:0] offset);
        return {4'b0, offset, qz, qx, vheight, index};
    endfunction

    // plane height through the chosen triangle, rounded, offset and saturated, or an outside result off the grid
    function automatic result_t predict_surface(
            input logic [hfth_pkg::IN_DATA_W-1:0] item);
        result_t res;
        longint  x, z, fx, fz, acc, h, total;
        longint  h00, h10, h01, h11;
        int      cols, rows, col, row, base;
        res   = '{height: '0, outside: 1'b1};
        cols  = clamp_side(grid_cols_cfg);
        rows  = clamp_side(grid_rows_cfg);
        x     = longint'($signed(item[75:44]));
        z     = longint'($signed(item[107:76]));
        if (x < 0 || z < 0 || cols < 2 || rows < 2)
            return res;
        col = int'(x >>> FRAC_BITS);
        row = int'(z >>> FRAC_BITS);
        if (col >= cols - 1 || row >= rows - 1)
            return res;
        fx   = x & (UNIT - 1);
        fz   = z & (UNIT - 1);
        base = row * cols + col;
        h00  = longint'($signed(height_mem[base]));
        h10  = longint'($signed(height_mem[base + 1]));
        h01  = longint'($signed(height_mem[base + cols]));
        h11  = longint'($signed(height_mem[base + cols + 1]));
        if (fx + fz > UNIT)
            acc = h11 * UNIT + (UNIT - fx) * (h01 - h11) + (UNIT - fz) * (h10 - h11);
        else
            acc = h00 * UNIT + fx * (h10 - h00) + fz * (h01 - h00);
        h     = (acc + (UNIT >>> 1)) >>> FRAC_BITS;
        total = h + longint'($signed(item[139:108]));
        if (total > SAT_HI)
            total = SAT_HI;
        if (total < SAT_LO)
            total = SAT_LO;
        res.height  = total[31:0];
        res.outside = 1'b0;
        return res;
    endfunction

    // try up to 20 random cells for one whose four corners have all been loaded
    function automatic bit pick_cell(output int col, output int row);
        int cols, rows, base;
        cols = clamp_side(grid_cols_cfg);
        rows = clamp_side(grid_rows_cfg);
        col  = 0;
        row  = 0;
        if (cols < 2 || rows < 2)
            return 1'b0;
        repeat (20) begin
            col  = $urandom_range(0, cols - 2);
            row  = $urandom_range(0, rows - 2);
            base = row * cols + col;
            if (height_loaded[base] && height_loaded[base + 1] &&
                height_loaded[base + cols] && height_loaded[base + cols + 1])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] rand_height();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0: return r;
            1: return {{8{r[23]}}, r[23:0]};
            2: return {{16{r[15]}}, r[15:0]};
            default: begin
                case (r[1:0])
                    2'd0:    return 32'h7FFFFFFF;
                    2'd1:    return 32'h80000000;
                    2'd2:    return 32'h00000000;
                    default: return 32'hFFFFFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // present one transaction, hold it until taken, then update the predictor
    task automatic send_item(input hfth_pkg::mode_t mode,
                             input logic [hfth_pkg::IN_DATA_W-1:0] item,
                             input bit typed, input result_t typed_res);
        int gap;
        gap = 0;
        if ($urandom_range(0, 39) == 0)
            sender_busy = !sender_busy;
        if (!quiet_tail && sender_busy && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
        if (mode == hfth_pkg::MODE_LOAD) begin
            height_mem[item[11:0]]    = item[43:12];
            height_loaded[item[11:0]] = 1'b1;
        end else begin
            pending_surfaces.push_back(typed ? typed_res : predict_surface(item));
        end
    endtask

    // stop sending and wait until every query result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_surfaces.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // write both grid registers on back-to-back edges
    task automatic set_grid(input int cols, input int rows);
        cfg_we    <= 1'b1;
        cfg_index <= hfth_pkg::REG_GRID_COLUMNS;
        cfg_wdata <= hfth_pkg::CFG_W'(cols);
        @(posedge aclk);
        grid_cols_cfg = hfth_pkg::CFG_W'(cols);
        cfg_index <= hfth_pkg::REG_GRID_ROWS;
        cfg_wdata <= hfth_pkg::CFG_W'(rows);
        @(posedge aclk);
        grid_rows_cfg = hfth_pkg::CFG_W'(rows);
        cfg_we <= 1'b0;
    endtask

    // check each result transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_surfaces.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got height %h outside %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pending_surfaces.pop_front();
                if (m_tdata !== want.height) begin
                    errors++;
                    $display("%0t: surface_height expected %h, got %h",
                             $time, want.height, m_tdata);
                end
                if (m_tuser !== want.outside) begin
                    errors++;
                    $display("%0t: outside_grid expected %b, got %b",
                             $time, want.outside, m_tuser);
                end
            end
        end
    end

    // result side backpressure: random stall bursts, none in the tail
    initial begin
        int stall;
        bit busy;
        stall    = 0;
        busy     = 1'b1;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 59) == 0)
                busy = !busy;
            if (quiet_tail) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (busy && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[heightfield_triangle_height] ERROR");
        $finish;
    end

    initial begin
        int                          cols_now, rows_now, area, c0, r0, c, r;
        logic [31:0]                 qx, qz;
        logic [hfth_pkg::IDX_W-1:0]  index;
        stim_row_t                   row_now;
        errors        = 0;
        quiet_tail    = 1'b0;
        sender_busy   = 1'b1;
        grid_cols_cfg = hfth_pkg::GRID_SIDE_RESET;
        grid_rows_cfg = hfth_pkg::GRID_SIDE_RESET;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = hfth_pkg::REG_GRID_COLUMNS;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = hfth_pkg::MODE_LOAD;
        foreach (height_loaded[i])
            height_loaded[i] = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table on the reset grid
        foreach (directed_rows[i]) begin
            row_now = directed_rows[i];
            send_item(row_now.mode,
                      pack_item(row_now.index, row_now.vheight, row_now.qx,
                                row_now.qz, row_now.offset),
                      row_now.typed, row_now.answer);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            if (p == NUM_PHASES - 1)
                quiet_tail = 1'b1;
            set_grid(phase_cols[p], phase_rows[p]);
            cols_now = clamp_side(grid_cols_cfg);
            rows_now = clamp_side(grid_rows_cfg);
            area     = cols_now * rows_now;

            // load the whole grid when small, else three 4 x 4 patches
            if (area <= 256) begin
                for (int i = 0; i < area; i++)
                    send_item(hfth_pkg::MODE_LOAD,
                              pack_item(hfth_pkg::IDX_W'(i), rand_height(),
                                        $urandom, $urandom, $urandom), 1'b0, '0);
            end else begin
                repeat (3) begin
                    c0 = $urandom_range(0, cols_now - 4);
                    r0 = $urandom_range(0, rows_now - 4);
                    for (int dr = 0; dr < 4; dr++)
                        for (int dc = 0; dc < 4; dc++)
                            send_item(hfth_pkg::MODE_LOAD,
                                      pack_item(hfth_pkg::IDX_W'((r0 + dr) * cols_now
                                                                 + c0 + dc),
                                                rand_height(), $urandom, $urandom,
                                                $urandom), 1'b0, '0);
                end
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off once per phase until the pipeline is empty
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                if ($urandom_range(0, 3) == 0) begin
                    if (area > 0 && $urandom_range(0, 1) == 1)
                        index = hfth_pkg::IDX_W'($urandom_range(0, area - 1));
                    else
                        index = hfth_pkg::IDX_W'($urandom_range(0, STORE_WORDS - 1));
                    send_item(hfth_pkg::MODE_LOAD,
                              pack_item(index, rand_height(), $urandom,
                                        $urandom, $urandom), 1'b0, '0);
                end else begin
                    if ($urandom_range(0, 9) < 7 && pick_cell(c, r)) begin
                        qx = {c[15:0], rand_frac()};
                        qz = {r[15:0], rand_frac()};
                    end else begin
                        case ($urandom_range(0, 3))
                            0: begin
                                // far away: never lands on an unloaded cell
                                qx = $urandom;
                                if (!qx[31])
                                    qx[30] = 1'b1;
                                qz = $urandom;
                            end
                            1: begin
                                qx = $urandom | 32'h80000000;
                                qz = {16'($urandom_range(0, 63)), rand_frac()};
                            end
                            2: begin
                                qx = {16'(cols_now - 1), rand_frac()};
                                qz = {16'($urandom_range(0, 63)), rand_frac()};
                            end
                            default: begin
                                qx = {16'($urandom_range(0, 63)), rand_frac()};
                                qz = {16'(rows_now - 1), rand_frac()};
                            end
                        endcase
                    end
                    send_item(hfth_pkg::MODE_QUERY,
                              pack_item(hfth_pkg::IDX_W'($urandom), $urandom, qx, qz,
                                        rand_height()), 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (errors == 0 && pending_surfaces.size() == 0)
            $display("[heightfield_triangle_height] OK");
        else
            $display("[heightfield_triangle_height] ERROR");
        $finish;
    end

endmodule
